@@ src/swms_pkg.sv @@
// Shared types and constants for the sliding-window maximum and sum block.
package swms_pkg;

    localparam int OFFSET_W = 32;
    localparam int SLOPE_W  = 16;
    localparam int VAL_W    = 48;
    localparam int POS_W    = 32;
    localparam int SUM_W    = 64;
    localparam int PROD_W   = 47;
    localparam int ENTRY_W  = POS_W + VAL_W;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 112;

    localparam int WLEN_W   = 7;
    localparam int ETIME_W  = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_TIME  = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_EVICT,
        S_EVICT_RD,
        S_POP,
        S_POP_RD,
        S_PUSH,
        S_FRONT_RD,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic load_prod;
        logic load_val;
        logic evict;
        logic pop;
        logic push;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic evict_hit;
        logic pop_hit;
        logic emit;
        logic out_busy;
    } status_t;

endpackage

@@ src/swms_ctrl.sv @@
// Sequencer for one item: evaluate, evict, pop, push, emit.
module swms_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  swms_pkg::status_t stat,
    output swms_pkg::cmd_t    cmd
);

    swms_pkg::state_t state_reg;
    swms_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swms_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            swms_pkg::S_IDLE: begin
                // hold off items while reset is applied
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = swms_pkg::S_MUL;
                end
            end
            swms_pkg::S_MUL: begin
                cmd.load_prod = 1'b1;
                state_next    = swms_pkg::S_ADD;
            end
            swms_pkg::S_ADD: begin
                cmd.load_val = 1'b1;
                state_next   = swms_pkg::S_EVICT;
            end
            swms_pkg::S_EVICT: begin
                if (stat.evict_hit) begin
                    cmd.evict  = 1'b1;
                    state_next = swms_pkg::S_EVICT_RD;
                end else begin
                    state_next = swms_pkg::S_POP;
                end
            end
            swms_pkg::S_EVICT_RD: begin
                state_next = swms_pkg::S_EVICT;
            end
            swms_pkg::S_POP: begin
                if (stat.pop_hit) begin
                    cmd.pop    = 1'b1;
                    state_next = swms_pkg::S_POP_RD;
                end else begin
                    state_next = swms_pkg::S_PUSH;
                end
            end
            swms_pkg::S_POP_RD: begin
                state_next = swms_pkg::S_POP;
            end
            swms_pkg::S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = swms_pkg::S_FRONT_RD;
            end
            swms_pkg::S_FRONT_RD: begin
                state_next = swms_pkg::S_EMIT;
            end
            swms_pkg::S_EMIT: begin
                // hold while a result is due and the output register is still full
                if (!(stat.emit && stat.out_busy)) begin
                    cmd.finish = 1'b1;
                    state_next = swms_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = swms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/swms_dp.sv @@
// Datapath: evaluation, deque memory and pointers, running sum, output register.
module swms_dp #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  swms_pkg::cmd_t                       cmd,
    output swms_pkg::status_t                    stat,
    input  logic [swms_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 cfg_valid,
    input  logic [swms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swms_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [swms_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tlast
);

    localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int KW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(WINDOW_DEPTH - 1);

    localparam int VW = swms_pkg::VAL_W;
    localparam int EW = swms_pkg::ENTRY_W;
    localparam int SW = swms_pkg::SUM_W;

    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // configuration
    logic [swms_pkg::WLEN_W-1:0]  window_len_reg;
    logic [swms_pkg::ETIME_W-1:0] eval_time_reg;

    // item payload
    logic signed [swms_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [swms_pkg::SLOPE_W-1:0]  slope_reg;
    logic                                  last_reg;
    logic signed [swms_pkg::PROD_W-1:0]   prod_reg;
    logic signed [VW-1:0]                 val_reg;

    // deque storage: position in the upper bits, value in the lower
    logic [EW-1:0] deque_mem [WINDOW_DEPTH];
    logic [EW-1:0] front_rd_reg;
    logic [EW-1:0] back_rd_reg;

    logic [PW-1:0]                 front_ptr_reg;
    logic [PW-1:0]                 back_ptr_reg;
    logic [KW-1:0]                 count_reg;
    logic [swms_pkg::POS_W-1:0]    elem_cnt_reg;
    logic signed [SW-1:0]          sum_reg;
    logic                          full_reg;

    logic                          m_valid_reg;
    logic [VW-1:0]                 max_out_reg;
    logic [SW-1:0]                 sum_out_reg;
    logic                          last_out_reg;

    logic [31:0]                   wl_ext;
    logic [KW-1:0]                 k_len;
    logic [swms_pkg::POS_W-1:0]    front_age;
    logic [PW-1:0]                 front_inc;
    logic [PW-1:0]                 back_inc;
    logic [PW-1:0]                 back_dec;
    logic                          full_hit;
    logic signed [VW-1:0]          front_val;
    logic signed [VW-1:0]          back_val;
    logic signed [SW:0]            sum_wide;
    logic signed [SW-1:0]          sum_sat;

    // effective window length, clamped to 1..WINDOW_DEPTH
    assign wl_ext = 32'(window_len_reg);
    always_comb begin
        if (wl_ext == 32'd0) begin
            k_len = KW'(1);
        end else if (wl_ext > 32'(WINDOW_DEPTH)) begin
            k_len = KW'(WINDOW_DEPTH);
        end else begin
            k_len = KW'(wl_ext);
        end
    end

    assign front_val = $signed(front_rd_reg[VW-1:0]);
    assign back_val  = $signed(back_rd_reg[VW-1:0]);
    assign front_age = elem_cnt_reg - front_rd_reg[EW-1:VW];

    assign front_inc = (front_ptr_reg == LAST_PTR) ? '0 : front_ptr_reg + 1'b1;
    assign back_inc  = (back_ptr_reg == LAST_PTR) ? '0 : back_ptr_reg + 1'b1;
    assign back_dec  = (back_ptr_reg == '0) ? LAST_PTR : back_ptr_reg - 1'b1;

    assign full_hit = ({1'b0, elem_cnt_reg} + 33'd1) >= 33'(k_len);

    // saturating add of the front value into the running sum
    assign sum_wide = (SW+1)'(sum_reg) + (SW+1)'(front_val);
    always_comb begin
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_sat = sum_wide[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SW-1:0];
        end
    end

    assign stat.evict_hit = (count_reg != '0) && (front_age >= 32'(k_len));
    assign stat.pop_hit   = (count_reg != '0) && (val_reg >= back_val);
    assign stat.emit      = full_reg || last_reg;
    assign stat.out_busy  = m_valid_reg && !m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= swms_pkg::WLEN_W'(1);
            eval_time_reg  <= '0;
            front_ptr_reg  <= '0;
            back_ptr_reg   <= '0;
            count_reg      <= '0;
            elem_cnt_reg   <= '0;
            sum_reg        <= '0;
            full_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    swms_pkg::CFG_WINDOW_LEN: window_len_reg <= cfg_data[swms_pkg::WLEN_W-1:0];
                    swms_pkg::CFG_EVAL_TIME:  eval_time_reg  <= cfg_data[swms_pkg::ETIME_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish && stat.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.evict) begin
                front_ptr_reg <= front_inc;
                count_reg     <= count_reg - 1'b1;
            end
            if (cmd.pop) begin
                back_ptr_reg <= back_dec;
                count_reg    <= count_reg - 1'b1;
            end
            if (cmd.push) begin
                back_ptr_reg <= back_inc;
                count_reg    <= count_reg + 1'b1;
                elem_cnt_reg <= elem_cnt_reg + 1'b1;
                if (full_hit) begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                // end of stream: drop the deque and start over
                if (last_reg) begin
                    front_ptr_reg <= '0;
                    back_ptr_reg  <= '0;
                    count_reg     <= '0;
                    elem_cnt_reg  <= '0;
                    sum_reg       <= '0;
                    full_reg      <= 1'b0;
                end else if (full_reg) begin
                    sum_reg <= sum_sat;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            offset_reg <= $signed(s_tdata[swms_pkg::OFFSET_W-1:0]);
            slope_reg  <= $signed(s_tdata[swms_pkg::S_DATA_W-1:swms_pkg::OFFSET_W]);
            last_reg   <= s_tlast;
        end
        if (cmd.load_prod) begin
            prod_reg <= slope_reg * $signed({1'b0, eval_time_reg});
        end
        if (cmd.load_val) begin
            val_reg <= VW'(offset_reg) + VW'(prod_reg);
        end
        if (cmd.finish && stat.emit) begin
            max_out_reg  <= front_rd_reg[VW-1:0];
            sum_out_reg  <= sum_sat;
            last_out_reg <= last_reg;
        end
    end

    // deque memory: one write, two registered reads at front and back
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            deque_mem[back_ptr_reg] <= {elem_cnt_reg, val_reg};
        end
        front_rd_reg <= deque_mem[front_ptr_reg];
        back_rd_reg  <= deque_mem[back_dec];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {sum_out_reg, max_out_reg};
    assign m_tlast  = last_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= KW'(WINDOW_DEPTH))
        else $error("deque count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> front_ptr_reg == back_ptr_reg)
        else $error("empty deque with unequal pointers");

    a_stream_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && last_reg |=> count_reg == '0 && elem_cnt_reg == '0 && !full_reg)
        else $error("stream state not cleared after final item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && stat.emit |-> !(m_valid_reg && !m_tready))
        else $error("result loaded over a pending result");

endmodule

@@ src/sliding_window_max_sum.sv @@
// Top level of the sliding-window maximum and saturating sum block.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid / s_tready  s_tdata {slope, offset}, s_tlast = last_in
//  m_        out        m_tvalid / m_tready  m_tdata {window_sum, window_max}, m_tlast
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item, once accepted, passes through the MUL, ADD, EVICT, POP, PUSH, FRONT_RD
// and EMIT states; its result is registered as it leaves EMIT and the next item is
// taken in IDLE after that. Each entry evicted from the front adds an EVICT_RD state
// and each popped from the back a POP_RD state, set by the registered read of the
// deque memory. Each element leaves the deque at most once. Items are taken one at a time.
// Reset (aresetn low, synchronous) clears the deque, counters, running sum and
// output valid and sets window_len to 1, eval_time to 0; s_tready and cfg_ready
// stay low while it is applied.
// A stalled m_tready holds the finished result; the next item is still accepted
// and runs until its own result is due. cfg_ready is high whenever out of reset.
module sliding_window_max_sum #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swms_pkg::S_DATA_W-1:0]     s_tdata,   // offset[31:0], slope[47:32]
    input  logic                              s_tlast,   // last_in
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swms_pkg::M_DATA_W-1:0]     m_tdata,   // window_max[47:0], window_sum[111:48]
    output logic                              m_tlast,   // last_out
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swms_pkg::CFG_IDX_W-1:0]    cfg_index, // 0: window_len, 1: eval_time
    input  logic [swms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    swms_pkg::cmd_t    cmd;
    swms_pkg::status_t stat;

    // registers are written in the cycle they arrive, once out of reset
    assign cfg_ready = aresetn;

    // sequencer: one item at a time through evaluate, evict, pop, push, emit
    swms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: linear evaluation, deque memory, running sum, result register
    swms_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ dv/sliding_window_max_sum_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window maximum and saturating sum block.
module sliding_window_max_sum_tb;

    localparam int DEPTH         = 64;
    localparam int RAND_ITEMS    = 650;
    // Settling wait, sized for an item's worst path to the result register through
    // every evicted and every popped entry.
    localparam int SETTLE_CYCLES = 300;

    // Spare register indexes; the block ignores writes to them.
    localparam logic [swms_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [swms_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t                      kind;
        logic [swms_pkg::OFFSET_W-1:0]   offset;
        logic [swms_pkg::SLOPE_W-1:0]    slope;
        logic                            last;
        logic [swms_pkg::CFG_IDX_W-1:0]  index;
        logic [swms_pkg::CFG_DATA_W-1:0] data;
    } step_t;

    typedef struct packed {
        logic [swms_pkg::VAL_W-1:0] wmax;
        logic [swms_pkg::SUM_W-1:0] wsum;
        logic                       wlast;
    } window_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [swms_pkg::S_DATA_W-1:0]     s_tdata   = '0;  // offset[31:0], slope[47:32]
    logic                              s_tlast   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [swms_pkg::M_DATA_W-1:0]     m_tdata;  // window_max[47:0], window_sum[111:48]
    logic                              m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [swms_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [swms_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    // Stimulus waiting for the driver, and results still owed by the block.
    step_t          pending_steps[$];
    window_result_t maxima_due[$];
    int             mismatches = 0;

    // Handshakes seen at the last rising edge, read by the driver on the falling edge.
    bit s_taken   = 1'b0;
    bit cfg_taken = 1'b0;

    // Sender burst/gap and receiver stall pattern state.
    int burst_left = 1;
    int gap_left   = 0;
    int quiet      = 0;
    int stall_mode = 0;
    int stall_left = 0;

    // Predictor state: registers, deque and stream bookkeeping.
    logic [swms_pkg::WLEN_W-1:0]  win_len = 7'd1;
    logic [swms_pkg::ETIME_W-1:0] eval_t  = '0;
    logic [swms_pkg::POS_W-1:0]   dq_pos[DEPTH];
    longint                       dq_val[DEPTH];
    int                           dq_front = 0;
    int                           dq_back  = 0;
    int                           dq_n     = 0;
    logic [swms_pkg::POS_W-1:0]   elem_cnt = '0;
    longint                       run_sum  = 0;
    bit                           win_full = 1'b0;

    sliding_window_max_sum #(
        .WINDOW_DEPTH(DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hold reset low from the start, then release it on a falling edge.
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint sat_sum(longint a, longint b);
        logic [swms_pkg::SUM_W:0] s;
        s = {a[swms_pkg::SUM_W-1], a} + {b[swms_pkg::SUM_W-1], b};
        if (s[swms_pkg::SUM_W] != s[swms_pkg::SUM_W-1])
            return s[swms_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
        return s[swms_pkg::SUM_W-1:0];
    endfunction

    // Advance the predicted deque by one element and queue the result it owes.
    task automatic track_window(input logic [swms_pkg::OFFSET_W-1:0] off,
                                input logic [swms_pkg::SLOPE_W-1:0] slp,
                                input logic lst);
        longint                     v;
        longint                     k;
        longint                     mx;
        longint                     sum;
        logic [swms_pkg::POS_W-1:0] idx;
        logic [swms_pkg::POS_W-1:0] age;
        window_result_t             r;
        k = longint'(win_len);
        if (k == 0) k = longint'(1);
        if (k > DEPTH) k = longint'(DEPTH);
        v = longint'($signed(off)) + longint'($signed(slp)) * longint'({34'd0, eval_t});
        idx = elem_cnt;
        // Drop entries that have aged out of the window.
        while (dq_n > 0) begin
            age = idx - dq_pos[dq_front];
            if (longint'({32'd0, age}) < k) break;
            dq_front = (dq_front + 1) % DEPTH;
            dq_n--;
        end
        // Drop back entries that the new value matches or beats.
        while (dq_n > 0 && v >= dq_val[(dq_back + DEPTH - 1) % DEPTH]) begin
            dq_back = (dq_back + DEPTH - 1) % DEPTH;
            dq_n--;
        end
        dq_pos[dq_back] = idx;
        dq_val[dq_back] = v;
        dq_back = (dq_back + 1) % DEPTH;
        dq_n++;
        elem_cnt = idx + 1;
        if (longint'({32'd0, idx}) + 1 >= k) win_full = 1'b1;
        mx = dq_val[dq_front];
        if (win_full) begin
            run_sum = sat_sum(run_sum, mx);
            sum = run_sum;
        end else begin
            sum = sat_sum(run_sum, mx);
        end
        if (win_full || lst) begin
            r.wmax  = mx[swms_pkg::VAL_W-1:0];
            r.wsum  = sum;
            r.wlast = lst;
            maxima_due.push_back(r);
        end
        // A final element closes the stream; the registers stay as written.
        if (lst) begin
            dq_front = 0;
            dq_back  = 0;
            dq_n     = 0;
            elem_cnt = '0;
            run_sum  = 0;
            win_full = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sample handshakes, track register writes and input items, check results.
    always @(posedge aclk) begin : watch_ports
        window_result_t due;
        s_taken   = aresetn && s_tvalid && s_tready;
        cfg_taken = aresetn && cfg_valid && cfg_ready;
        if (cfg_taken) begin
            case (cfg_index)
                swms_pkg::CFG_WINDOW_LEN: win_len = cfg_data[swms_pkg::WLEN_W-1:0];
                swms_pkg::CFG_EVAL_TIME:  eval_t  = cfg_data[swms_pkg::ETIME_W-1:0];
                default: ;
            endcase
        end
        if (s_taken)
            track_window(s_tdata[swms_pkg::OFFSET_W-1:0],
                         s_tdata[swms_pkg::S_DATA_W-1:swms_pkg::OFFSET_W], s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (maxima_due.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                due = maxima_due.pop_front();
                if (m_tdata[swms_pkg::VAL_W-1:0] !== due.wmax)
                    report_mismatch("window_max", 64'(m_tdata[swms_pkg::VAL_W-1:0]),
                                    64'(due.wmax));
                if (m_tdata[swms_pkg::VAL_W+swms_pkg::SUM_W-1:swms_pkg::VAL_W] !== due.wsum)
                    report_mismatch("window_sum",
                                    m_tdata[swms_pkg::VAL_W+swms_pkg::SUM_W-1:swms_pkg::VAL_W],
                                    due.wsum);
                if (m_tlast !== due.wlast)
                    report_mismatch("last_out", 64'(m_tlast), 64'(due.wlast));
            end
        end
    end

    // Drive on the falling edge: hold an offered item until taken, then take the
    // next step from the queue. Each signal gets exactly one assignment per edge.
    always @(negedge aclk) begin : drive_inputs
        logic                            nxt_valid;
        logic [swms_pkg::S_DATA_W-1:0]   nxt_data;
        logic                            nxt_last;
        logic                            nxt_cvalid;
        logic [swms_pkg::CFG_IDX_W-1:0]  nxt_idx;
        logic [swms_pkg::CFG_DATA_W-1:0] nxt_cdata;
        logic                            nxt_ready;
        step_t                           head;
        nxt_valid  = s_tvalid && !s_taken;
        nxt_data   = s_tdata;
        nxt_last   = s_tlast;
        nxt_cvalid = cfg_valid && !cfg_taken;
        nxt_idx    = cfg_index;
        nxt_cdata  = cfg_data;
        if (aresetn && !nxt_valid && !nxt_cvalid && pending_steps.size() != 0) begin
            head = pending_steps[0];
            case (head.kind)
                OP_ITEM: begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_data  = {head.slope, head.offset};
                        nxt_last  = head.last;
                        void'(pending_steps.pop_front());
                        burst_left--;
                        // Start a new burst; some bursts follow with no gap at all.
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                OP_CFG: begin
                    nxt_cvalid = 1'b1;
                    nxt_idx    = head.index;
                    nxt_cdata  = head.data;
                    void'(pending_steps.pop_front());
                end
                default: begin
                    // Wait for every owed result, then let the block settle.
                    quiet = (maxima_due.size() == 0) ? quiet + 1 : 0;
                    if (quiet >= SETTLE_CYCLES) begin
                        quiet = 0;
                        void'(pending_steps.pop_front());
                    end
                end
            endcase
        end
        // Receiver: switch among always-ready, random, sparse and periodic patterns.
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       nxt_ready = 1'b1;
            1:       nxt_ready = 1'($urandom_range(0, 1));
            2:       nxt_ready = ($urandom_range(0, 7) == 0);
            default: nxt_ready = (stall_left % 5) < 2;
        endcase
        s_tvalid  <= nxt_valid;
        s_tdata   <= nxt_data;
        s_tlast   <= nxt_last;
        cfg_valid <= nxt_cvalid;
        cfg_index <= nxt_idx;
        cfg_data  <= nxt_cdata;
        m_tready  <= nxt_ready;
    end

    task automatic add_item(input logic [swms_pkg::OFFSET_W-1:0] off,
                            input logic [swms_pkg::SLOPE_W-1:0] slp,
                            input logic lst);
        step_t s;
        s.kind   = OP_ITEM;
        s.offset = off;
        s.slope  = slp;
        s.last   = lst;
        s.index  = '0;
        s.data   = '0;
        pending_steps.push_back(s);
    endtask

    // Register writes must land on an idle block, which the block itself does not enforce, so settle first.
    task automatic add_cfg(input logic [swms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swms_pkg::CFG_DATA_W-1:0] val);
        step_t s;
        s.kind   = OP_DRAIN;
        s.offset = '0;
        s.slope  = '0;
        s.last   = 1'b0;
        s.index  = '0;
        s.data   = '0;
        pending_steps.push_back(s);
        s.kind  = OP_CFG;
        s.index = idx;
        s.data  = val;
        pending_steps.push_back(s);
    endtask

    // Sometimes set the unused upper bits of a register write.
    function automatic logic [swms_pkg::CFG_DATA_W-1:0] with_noise(
        logic [swms_pkg::CFG_DATA_W-1:0] val, int width);
        if ($urandom_range(0, 3) == 0)
            return ($urandom << width) | val;
        return val;
    endfunction

    initial begin
        int                            rand_count;
        int                            r;
        int                            wl;
        int                            k;
        int                            len;
        int                            style;
        int                            step;
        bit                            closed;
        logic [swms_pkg::ETIME_W-1:0]  et;
        logic [swms_pkg::OFFSET_W-1:0] base;
        logic [swms_pkg::OFFSET_W-1:0] off;
        logic [swms_pkg::SLOPE_W-1:0]  slp;
        logic [swms_pkg::OFFSET_W-1:0] edge_offs[4];
        logic [swms_pkg::SLOPE_W-1:0]  edge_slps[4];
        edge_offs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        edge_slps = '{16'h8000, 16'h7FFF, 16'h0, 16'hFFFF};

        // Directed: field extremes at evaluation time 1000000000, window of 3.
        add_cfg(swms_pkg::CFG_WINDOW_LEN, 32'd3);
        add_cfg(swms_pkg::CFG_EVAL_TIME, 32'd1_000_000_000);
        add_item(32'h8000_0000, 16'h8000, 1'b0);
        add_item(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        add_item(32'h0, 16'h0, 1'b0);
        add_item(32'hFFFF_FFFF, 16'h0001, 1'b0);
        add_item(32'd5, 16'hFFF9, 1'b1);
        // Stream that ends before the window fills, with a tie on the back entry.
        add_item(32'd10, 16'h0, 1'b0);
        add_item(32'd10, 16'h0, 1'b1);
        // Window length of zero acts as one; all-ones eval_time with upper bits set.
        add_cfg(swms_pkg::CFG_WINDOW_LEN, 32'hFFFF_FF80);
        add_cfg(swms_pkg::CFG_EVAL_TIME, 32'hFFFF_FFFF);
        add_item(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        add_item(32'h8000_0000, 16'h8000, 1'b1);
        add_cfg(CFG_SPARE_A, $urandom);
        add_cfg(CFG_SPARE_B, $urandom);
        // Oversized window saturates to the deque depth; stream ends short.
        add_cfg(swms_pkg::CFG_WINDOW_LEN, 32'd127);
        add_cfg(swms_pkg::CFG_EVAL_TIME, 32'd0);
        add_item(32'd3, 16'h1234, 1'b0);
        add_item(32'hFFFF_FFF0, 16'h0, 1'b0);
        add_item(32'd9, 16'h0, 1'b0);
        add_item(32'd1, 16'h0, 1'b1);
        // Shrink the window mid-stream: a decreasing deque of eight entries mostly evicts at once.
        add_cfg(swms_pkg::CFG_WINDOW_LEN, 32'd64);
        for (int j = 0; j < 8; j++)
            add_item(32'd100 - j, 16'h0, 1'b0);
        add_cfg(swms_pkg::CFG_WINDOW_LEN, 32'd2);
        add_item(32'd50, 16'h0, 1'b0);
        add_item(32'd60, 16'h0, 1'b0);
        add_item(32'd55, 16'h0, 1'b1);

        // Random phases: new settings, then a stream of a chosen shape.
        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r == 0)      wl = 0;
            else if (r == 1) wl = 64;
            else if (r == 2) wl = $urandom_range(65, 127);
            else if (r < 6)  wl = $urandom_range(9, 63);
            else             wl = $urandom_range(1, 8);
            add_cfg(swms_pkg::CFG_WINDOW_LEN, with_noise(wl, swms_pkg::WLEN_W));
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 9);
                if (r == 0)      et = '0;
                else if (r == 1) et = '1;
                else if (r == 2) et = 30'd1_000_000_000;
                else if (r < 6)  et = swms_pkg::ETIME_W'($urandom_range(0, 1000));
                else             et = swms_pkg::ETIME_W'($urandom_range(0, 1_000_000_000));
                add_cfg(swms_pkg::CFG_EVAL_TIME, with_noise(32'(et), swms_pkg::ETIME_W));
            end
            k = (wl == 0) ? 1 : ((wl > DEPTH) ? DEPTH : wl);
            len = $urandom_range(1, (3 * k + 4 > 140) ? 140 : 3 * k + 4);
            style = $urandom_range(0, 4);
            base = $urandom;
            step = $urandom_range(1, 1000);
            // Leave some streams open so the next settings apply mid-stream.
            closed = ($urandom_range(0, 6) != 0);
            for (int j = 0; j < len; j++) begin
                case (style)
                    0: begin
                        off = $urandom;
                        slp = swms_pkg::SLOPE_W'($urandom);
                    end
                    1: begin
                        off = $urandom_range(0, 3);
                        slp = swms_pkg::SLOPE_W'($urandom_range(0, 1));
                    end
                    2: begin
                        off = base + j * step;
                        slp = '0;
                    end
                    3: begin
                        off = base - j * step;
                        slp = '0;
                    end
                    default: begin
                        off = edge_offs[$urandom_range(0, 3)];
                        slp = edge_slps[$urandom_range(0, 3)];
                    end
                endcase
                add_item(off, slp, closed && (j == len - 1));
            end
            rand_count += len;
        end

        // Wait for the queue to empty and every result to arrive, then settle.
        while (pending_steps.size() != 0 || s_tvalid || maxima_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && maxima_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
